// ===== design/gate_control_list_builder_unit_assert.svh =====
// Assertion macros used by the checker file of the gate control list builder.
`ifndef GATE_CONTROL_LIST_BUILDER_UNIT_ASSERT_SVH
`define GATE_CONTROL_LIST_BUILDER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define GCLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GCLB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/gclb_pkg.sv =====
// Types, constants and helpers of the gate control list builder.
`timescale 1ns / 1ps
package gclb_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned QueW   = 3;
  localparam int unsigned QcW    = 4;
  localparam int unsigned RsvW   = 31;
  localparam int unsigned AddrW  = 2;
  localparam int unsigned WordW  = 72;
  localparam int unsigned StepW  = 7;

  // Configuration register indexes.
  localparam logic [AddrW-1:0] RegCycle   = 2'd0;
  localparam logic [AddrW-1:0] RegReserve = 2'd1;
  localparam logic [AddrW-1:0] RegQueues  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [TimeW-1:0] CycleRst   = 32'd1000000;
  localparam logic [RsvW-1:0]  ReserveRst = 31'd0;
  localparam logic [QcW-1:0]   QueuesRst  = 4'd8;

  // Output steps of one job, emitted lowest first.
  localparam int unsigned StepLead  = 0; // held entry or leading opening
  localparam int unsigned StepGap   = 1;
  localparam int unsigned StepFin   = 2; // final held entry
  localparam int unsigned StepTailA = 3; // guard band before all-open span
  localparam int unsigned StepTailB = 4; // all-open span
  localparam int unsigned StepTailC = 5; // guard band up to cycle end
  localparam int unsigned StepTailS = 6; // single closed span

  typedef logic [TimeW-1:0] time_t;
  typedef logic [MaskW-1:0] mask_t;

  typedef struct packed {
    logic  e0_v;
    time_t e0_start;
    time_t e0_stop;
    mask_t e0_mask;
    logic  gap_v;
    time_t gap_start;
    time_t gap_stop;
    mask_t gap_mask;
    logic  fin_v;
    time_t fin_start;
    time_t fin_stop;
    mask_t fin_mask;
  } job_t;

  // All-gates-open mask; counts above the gate count saturate.
  function automatic mask_t all_open(input logic [QcW-1:0] qc);
    mask_t m;
    m = '0;
    if (qc >= QcW'(MaskW)) begin
      m = '1;
    end else begin
      m = mask_t'((9'd1 << qc) - 9'd1);
    end
    return m;
  endfunction

endpackage

// ===== design/gclb_fifo.sv =====
// Two-entry job queue between the classifier and the entry sequencer.
`timescale 1ns / 1ps
module gclb_fifo
  import gclb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== design/gclb_front.sv =====
// Window classifier: holds the open entry and turns each window into a job.
`timescale 1ns / 1ps
module gclb_front
  import gclb_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  time_t          win_start_i,
  input  time_t          win_stop_i,
  input  logic [QueW-1:0] queue_i,
  input  logic           last_i,
  input  logic [QcW-1:0] queue_count_i,
  output logic           push_o,
  output job_t           job_o
);

  logic  have_q, have_d;
  time_t hs_q, hs_d;
  time_t he_q, he_d;
  mask_t hm_q, hm_d;

  mask_t bit_w;
  mask_t all_w;
  time_t ns;
  time_t ne;
  mask_t nm;

  assign bit_w = mask_t'(9'd1 << queue_i);
  assign all_w = all_open(queue_count_i);

  always_comb begin
    job_o = '0;
    ns    = win_start_i;
    ne    = win_stop_i;
    nm    = bit_w;
    if (!have_q) begin
      // leading opening of every other gate
      job_o.e0_v     = (win_start_i != '0);
      job_o.e0_start = '0;
      job_o.e0_stop  = win_start_i;
      job_o.e0_mask  = all_w & ~bit_w;
    end else if (he_q < win_start_i) begin
      job_o.e0_v      = 1'b1;
      job_o.e0_start  = hs_q;
      job_o.e0_stop   = he_q;
      job_o.e0_mask   = hm_q;
      job_o.gap_v     = 1'b1;
      job_o.gap_start = he_q;
      job_o.gap_stop  = win_start_i;
      job_o.gap_mask  = all_w & ~hm_q & ~bit_w;
    end else if (hm_q == bit_w) begin
      // extend the held entry, even to an earlier stop
      ns = hs_q;
      nm = hm_q;
    end else begin
      job_o.e0_v     = 1'b1;
      job_o.e0_start = hs_q;
      job_o.e0_stop  = he_q;
      job_o.e0_mask  = hm_q;
    end
    job_o.fin_v     = last_i;
    job_o.fin_start = ns;
    job_o.fin_stop  = ne;
    job_o.fin_mask  = nm;

    push_o = accept_i && (job_o.e0_v || job_o.gap_v || job_o.fin_v);

    have_d = have_q;
    hs_d   = hs_q;
    he_d   = he_q;
    hm_d   = hm_q;
    if (accept_i) begin
      have_d = !last_i;
      hs_d   = last_i ? '0 : ns;
      he_d   = last_i ? '0 : ne;
      hm_d   = last_i ? '0 : nm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      hs_q   <= '0;
      he_q   <= '0;
      hm_q   <= '0;
    end else begin
      have_q <= have_d;
      hs_q   <= hs_d;
      he_q   <= he_d;
      hm_q   <= hm_d;
    end
  end

endmodule

// ===== design/gclb_back.sv =====
// Entry sequencer: expands queued jobs into gate control entries, one a cycle unless the output stalls.
`timescale 1ns / 1ps
module gclb_back
  import gclb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  job_t            job_i,
  output logic            pop_o,
  input  time_t           cycle_len_i,
  input  logic [RsvW-1:0] guard_len_i,
  input  logic [QcW-1:0]  queue_count_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output time_t           out_start_o,
  output time_t           out_stop_o,
  output mask_t           out_mask_o,
  output logic            out_last_o
);

  job_t             cur_q;
  logic [StepW-1:0] pend_q, pend_d;
  time_t            lr_q;   // tail stop plus reserve
  time_t            cr_q;   // cycle end minus reserve
  logic             ov_q, ov_d;
  time_t            os_q, oe_q;
  mask_t            om_q;
  logic             ol_q;

  logic [StepW-1:0] sel;
  logic [StepW-1:0] pend_left;
  logic [StepW-1:0] new_pend;
  logic             emit_ok;
  logic             fire;
  logic             load;
  time_t            span;
  logic             tail_long;
  time_t            es, ee;
  mask_t            em;
  logic             el;

  assign emit_ok = !ov_q || out_ready_i;
  assign fire    = emit_ok && (pend_q != '0);
  assign sel     = pend_q & (~pend_q + StepW'(1));

  assign pend_left = fire ? (pend_q & ~sel) : pend_q;
  assign load      = job_valid_i && (pend_left == '0);
  assign pop_o     = load;

  // Tail shape of the incoming job; the span is only used when the stop lies
  // before the cycle end, so it never wraps there.
  assign span      = cycle_len_i - job_i.fin_stop;
  assign tail_long = (job_i.fin_stop < cycle_len_i) &&
                     (span > {guard_len_i, 1'b0});

  always_comb begin
    new_pend            = '0;
    new_pend[StepLead]  = job_i.e0_v;
    new_pend[StepGap]   = job_i.gap_v;
    new_pend[StepFin]   = job_i.fin_v;
    new_pend[StepTailA] = job_i.fin_v && tail_long;
    new_pend[StepTailB] = job_i.fin_v && tail_long;
    new_pend[StepTailC] = job_i.fin_v && tail_long;
    new_pend[StepTailS] = job_i.fin_v && !tail_long;
    pend_d = load ? new_pend : pend_left;
  end

  // Entry for the lowest pending step.
  always_comb begin
    es = cur_q.e0_start;
    ee = cur_q.e0_stop;
    em = cur_q.e0_mask;
    el = 1'b0;
    if (sel[StepGap]) begin
      es = cur_q.gap_start;
      ee = cur_q.gap_stop;
      em = cur_q.gap_mask;
    end else if (sel[StepFin]) begin
      es = cur_q.fin_start;
      ee = cur_q.fin_stop;
      em = cur_q.fin_mask;
    end else if (sel[StepTailA]) begin
      es = cur_q.fin_stop;
      ee = lr_q;
      em = '0;
    end else if (sel[StepTailB]) begin
      es = lr_q;
      ee = cr_q;
      em = all_open(queue_count_i);
    end else if (sel[StepTailC]) begin
      es = cr_q;
      ee = cycle_len_i;
      em = '0;
      el = 1'b1;
    end else if (sel[StepTailS]) begin
      es = cur_q.fin_stop;
      ee = cycle_len_i;
      em = '0;
      el = 1'b1;
    end
    ov_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= job_i;
      lr_q  <= job_i.fin_stop + {1'b0, guard_len_i};
      cr_q  <= cycle_len_i - {1'b0, guard_len_i};
    end
    if (fire) begin
      os_q <= es;
      oe_q <= ee;
      om_q <= em;
      ol_q <= el;
    end
  end

  assign out_valid_o = ov_q;
  assign out_start_o = os_q;
  assign out_stop_o  = oe_q;
  assign out_mask_o  = om_q;
  assign out_last_o  = ol_q;

endmodule

// ===== design/gate_control_list_builder_unit.sv =====
// Top level of the time-aware gate control list builder.
`timescale 1ns / 1ps
// Usage:
//   Configure the cycle length, the guard band and the queue count through
//   cfg_* while the block is idle. Then stream one interface's windows, sorted
//   by start, on the s_axis channel; tlast marks the final window. The m_axis
//   channel returns the gate control entries in order; tlast marks the final
//   entry of the list.
// Path: a window's first entry passes the job queue, the sequencer's step
//   register and the output register before it shows on m_axis.
// Throughput: the classifier takes a window word every cycle while the two-entry
//   job queue has room; the sequencer emits one entry word per cycle while the
//   output is not stalled, and a window yields at most six entries, maybe none.
//   The sequencer's one-entry-per-cycle output, when unstalled, sets the sustained rate.
// Reset: clears the held entry, the job queue and the output register and
//   loads the configuration defaults (cycle 1000000, reserve 0, eight queues).
// Stall: when m_axis_tready_i is low the output word holds, the job queue
//   fills, and s_axis_tready_o drops once both queue entries are taken.
module gate_control_list_builder_unit
  import gclb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // window_start, window_stop, queue_number, zero fill
  input  logic [WordW-1:0]  s_axis_tdata_i,
  input  logic              s_axis_tlast_i,   // last_window
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // entry_start, entry_stop, gate_mask
  output logic [WordW-1:0]  m_axis_tdata_o,
  output logic              m_axis_tlast_o,   // last_entry
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  input  logic              cfg_we_i,
  input  logic [AddrW-1:0]  cfg_addr_i,
  input  logic [TimeW-1:0]  cfg_wdata_i
);

  // Configuration registers.
  time_t           cycle_q;
  logic [RsvW-1:0] reserve_q;
  logic [QcW-1:0]  queues_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q   <= CycleRst;
      reserve_q <= ReserveRst;
      queues_q  <= QueuesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegCycle:   cycle_q   <= cfg_wdata_i;
        RegReserve: reserve_q <= cfg_wdata_i[RsvW-1:0];
        RegQueues:  queues_q  <= cfg_wdata_i[QcW-1:0];
        default: ;  // no register here: drop the write
      endcase
    end
  end

  logic  q_full;
  logic  in_accept;
  logic  push;
  job_t  push_job;
  logic  pop;
  logic  head_valid;
  job_t  head_job;
  time_t out_start, out_stop;
  mask_t out_mask;

  // Take a window word whenever the job queue has room.
  assign s_axis_tready_o = !q_full;
  assign in_accept       = s_axis_tvalid_i && !q_full;

  gclb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .win_start_i   (s_axis_tdata_i[TimeW-1:0]),
    .win_stop_i    (s_axis_tdata_i[2*TimeW-1:TimeW]),
    .queue_i       (s_axis_tdata_i[2*TimeW+QueW-1:2*TimeW]),
    .last_i        (s_axis_tlast_i),
    .queue_count_i (queues_q),
    .push_o        (push),
    .job_o         (push_job)
  );

  gclb_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_job)
  );

  gclb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (head_valid),
    .job_i          (head_job),
    .pop_o          (pop),
    .cycle_len_i    (cycle_q),
    .guard_len_i    (reserve_q),
    .queue_count_i  (queues_q),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_start_o    (out_start),
    .out_stop_o     (out_stop),
    .out_mask_o     (out_mask),
    .out_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_mask, out_stop, out_start};

endmodule

// ===== design/gclb_checker.sv =====
// Port-level checker for the gate control list builder, bound to the top level.
`timescale 1ns / 1ps
`include "gate_control_list_builder_unit_assert.svh"
module gclb_checker
  import gclb_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready_i,
  input logic [WordW-1:0] m_axis_tdata_i,
  input logic             m_axis_tlast_i,
  input logic             m_axis_tvalid_i,
  input logic             m_axis_tready_i
);

  `GCLB_ASSERT_RST(a_idle_in_reset, !rst_ni |-> !m_axis_tvalid_i, "output word during reset")
  `GCLB_ASSERT_RST(a_ready_in_reset, !rst_ni |-> s_axis_tready_i, "input not ready in reset")
  `GCLB_ASSERT(a_closing_shut, m_axis_tvalid_i && m_axis_tlast_i |-> m_axis_tdata_i[WordW-1:2*TimeW] == '0, "closing entry with open gates")
  `GCLB_ASSERT(a_valid_holds, m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i, "output word dropped under stall")
  `GCLB_ASSERT(a_word_holds, m_axis_tvalid_i && !m_axis_tready_i |=> $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i), "output word changed under stall")

endmodule

bind gate_control_list_builder_unit gclb_checker u_gclb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

// ===== verif/gate_control_list_builder_unit_test.sv =====
// Self-checking testbench of the gate control list builder: windows in, gate entries out.
`timescale 1ns / 1ps
module gate_control_list_builder_unit_test;
  import gclb_pkg::*;

  localparam int unsigned ReportCap     = 30;     // mismatch lines printed at most
  localparam int unsigned DrainLimit    = 50000;  // cycles to wait for the last entries
  localparam int unsigned SettleCycles  = 8;      // pipeline depth plus margin
  localparam int unsigned HoldOffCycles = 150;    // long receiver hold-off
  localparam int unsigned PhaseWindows  = 136;    // random windows per idle mix

  // One window word as the sender sees it.
  typedef struct packed {
    time_t           win_start;
    time_t           win_stop;
    logic [QueW-1:0] queue;
    logic            closes_list;
  } window_t;

  // One gate control entry word.
  typedef struct packed {
    time_t ent_start;
    time_t ent_stop;
    mask_t gates;
    logic  closes_list;
  } gate_entry_t;

  // Tracks the register copy and the held entry, predicts the entries each
  // window yields and compares the returned words against them in order.
  class gate_list_scoreboard;
    time_t            cycle_len;
    logic [RsvW-1:0]  guard_len;
    logic [QcW-1:0]   queue_cnt;
    bit               held_valid;
    time_t            held_start;
    time_t            held_stop;
    mask_t            held_gates;
    gate_entry_t      pending_entries[$];
    int unsigned      errors;
    int unsigned      windows_seen;
    int unsigned      entries_seen;
    int unsigned      lists_closed;
    int unsigned      settings_used;

    function new();
      cycle_len     = CycleRst;
      guard_len     = ReserveRst;
      queue_cnt     = QueuesRst;
      held_valid    = 1'b0;
      held_start    = '0;
      held_stop     = '0;
      held_gates    = '0;
      errors        = 0;
      windows_seen  = 0;
      entries_seen  = 0;
      lists_closed  = 0;
      settings_used = 0;
    endfunction

    function void write_reg(input logic [AddrW-1:0] idx, input logic [TimeW-1:0] value);
      case (idx)
        RegCycle:   cycle_len = value;
        RegReserve: guard_len = value[RsvW-1:0];
        RegQueues:  queue_cnt = value[QcW-1:0];
        default: ;
      endcase
    endfunction

    // Gates 0 .. queue_cnt-1 open; counts past the gate count open every gate.
    function mask_t open_gates();
      mask_t m;
      for (int q = 0; q < MaskW; q++) m[q] = (q < queue_cnt);
      return m;
    endfunction

    function void add_entry(input time_t s, input time_t e, input mask_t g, input logic l);
      pending_entries.push_back('{s, e, g, l});
    endfunction

    function void hold(input window_t w, input mask_t g);
      held_valid = 1'b1;
      held_start = w.win_start;
      held_stop  = w.win_stop;
      held_gates = g;
    endfunction

    function void note_window(input window_t w);
      mask_t           gate_bit;
      mask_t           all;
      logic [TimeW:0]  span;
      time_t           guard;
      gate_bit = mask_t'(1) << w.queue;
      all      = open_gates();
      windows_seen++;
      if (!held_valid) begin
        // leading opening of every other gate up to the first window
        if (w.win_start != '0) add_entry('0, w.win_start, all & ~gate_bit, 1'b0);
        hold(w, gate_bit);
      end else if (held_stop < w.win_start) begin
        add_entry(held_start, held_stop, held_gates, 1'b0);
        add_entry(held_stop, w.win_start, all & ~held_gates & ~gate_bit, 1'b0);
        hold(w, gate_bit);
      end else if (held_gates == gate_bit) begin
        // same queue touching or overlapping: stretch, even backwards
        held_stop = w.win_stop;
      end else begin
        add_entry(held_start, held_stop, held_gates, 1'b0);
        hold(w, gate_bit);
      end
      if (w.closes_list) begin
        add_entry(held_start, held_stop, held_gates, 1'b0);
        guard = {1'b0, guard_len};
        span  = {1'b0, cycle_len} - {1'b0, held_stop};
        if (held_stop < cycle_len && span > {1'b0, guard_len, 1'b0}) begin
          add_entry(held_stop, held_stop + guard, '0, 1'b0);
          add_entry(held_stop + guard, cycle_len - guard, all, 1'b0);
          add_entry(cycle_len - guard, cycle_len, '0, 1'b1);
        end else begin
          add_entry(held_stop, cycle_len, '0, 1'b1);
        end
        held_valid = 1'b0;
        held_start = '0;
        held_stop  = '0;
        held_gates = '0;
        lists_closed++;
      end
    endfunction

    function void mismatch(input string field, input logic [TimeW-1:0] want,
                           input logic [TimeW-1:0] got);
      errors++;
      if (errors <= ReportCap)
        $display("%0t: entry %0d %s expected %h got %h", $time, entries_seen, field, want, got);
    endfunction

    function void check_entry(input gate_entry_t got);
      gate_entry_t want;
      entries_seen++;
      if (pending_entries.size() == 0) begin
        errors++;
        if (errors <= ReportCap)
          $display("%0t: entry %0d not expected: start %h stop %h gates %h last %b",
                   $time, entries_seen, got.ent_start, got.ent_stop, got.gates, got.closes_list);
        return;
      end
      want = pending_entries.pop_front();
      if (got.ent_start !== want.ent_start) mismatch("entry_start", want.ent_start, got.ent_start);
      if (got.ent_stop !== want.ent_stop) mismatch("entry_stop", want.ent_stop, got.ent_stop);
      if (got.gates !== want.gates)
        mismatch("gate_mask", TimeW'(want.gates), TimeW'(got.gates));
      if (got.closes_list !== want.closes_list)
        mismatch("last_entry", TimeW'(want.closes_list), TimeW'(got.closes_list));
    endfunction
  endclass

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b1;
  logic [WordW-1:0]  s_axis_tdata_i  = '0;
  logic              s_axis_tlast_i  = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [WordW-1:0]  m_axis_tdata_o;
  logic              m_axis_tlast_o;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [AddrW-1:0]  cfg_addr_i      = '0;
  logic [TimeW-1:0]  cfg_wdata_i     = '0;

  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  bit                  stall_req     = 1'b0;
  gate_list_scoreboard board         = new();

  gate_control_list_builder_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // Entry sink: sample each handshake with the values that stood before the
  // edge, then pick tready for the next cycle. A pending hold-off request
  // parks tready low for a long stretch so the job queue backs up.
  initial begin : entry_sink
    int unsigned hold_left;
    gate_entry_t got;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '{m_axis_tdata_o[TimeW-1:0], m_axis_tdata_o[2*TimeW-1:TimeW],
                m_axis_tdata_o[2*TimeW+MaskW-1:2*TimeW], m_axis_tlast_o};
        board.check_entry(got);
      end
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic window_t win(input time_t s, input time_t e, input int unsigned q,
                                  input bit l);
    window_t w;
    w.win_start   = s;
    w.win_stop    = e;
    w.queue       = QueW'(q);
    w.closes_list = l;
    return w;
  endfunction

  // Uniform pick in [0, bound], bound may reach the full time range.
  function automatic time_t rand_upto(input logic [TimeW:0] bound);
    if (bound >= {1'b0, {TimeW{1'b1}}}) return $urandom;
    return $urandom_range(bound[TimeW-1:0], 0);
  endfunction

  function automatic time_t clamp_time(input logic [TimeW:0] t);
    return t[TimeW] ? '1 : t[TimeW-1:0];
  endfunction

  // Offer one window word; idle first at random, hold until accepted.
  task automatic offer_window(input window_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tlast_i  <= w.closes_list;
    s_axis_tdata_i  <= {{(WordW-2*TimeW-QueW){1'b0}}, w.queue, w.win_stop, w.win_start};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_window(w);
  endtask

  // Drop valid, wait for every expected entry, then let the pipeline empty.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid_i <= 1'b0;
    while (board.pending_entries.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all three registers back to back while the block is idle.
  task automatic configure(input time_t cyc, input logic [TimeW-1:0] rsv,
                           input logic [TimeW-1:0] qc);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= RegCycle;
    cfg_wdata_i <= cyc;
    @(posedge clk_i);
    cfg_addr_i  <= RegReserve;
    cfg_wdata_i <= rsv;
    @(posedge clk_i);
    cfg_addr_i  <= RegQueues;
    cfg_wdata_i <= qc;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.write_reg(RegCycle, cyc);
    board.write_reg(RegReserve, rsv);
    board.write_reg(RegQueues, qc);
    board.settings_used++;
  endtask

  // Random register set: short, medium and full-range cycles, guard bands
  // from none to half the range, queue counts mostly legal.
  task automatic pick_settings();
    time_t             cyc;
    logic [TimeW-1:0]  rsv;
    logic [TimeW-1:0]  qc;
    case ($urandom_range(5))
      0:       cyc = $urandom_range(64, 1);
      1, 2:    cyc = $urandom_range(200000, 1000);
      3:       cyc = $urandom;
      4:       cyc = '1;
      default: cyc = CycleRst;
    endcase
    if (cyc == '0) cyc = 1;
    case ($urandom_range(4))
      0:       rsv = '0;
      1:       rsv = $urandom_range(16);
      2:       rsv = cyc >> $urandom_range(6, 2);
      3:       rsv = $urandom & 32'h7FFF_FFFF;
      default: rsv = 32'h7FFF_FFFF;
    endcase
    qc = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
    configure(cyc, rsv, qc);
  endtask

  // One list: windows sorted by start that touch, overlap or leave gaps,
  // runs of the same queue, with a few scrambled words mixed in.
  task automatic random_list(output int unsigned count);
    int unsigned     n;
    int unsigned     q;
    logic [TimeW:0]  stride;
    logic [TimeW:0]  s;
    logic [TimeW:0]  e;
    window_t         w;
    n      = $urandom_range(8, 1);
    stride = {1'b0, board.cycle_len} / (TimeW+1)'(2 * n);
    if (stride == '0) stride = {{TimeW{1'b0}}, 1'b1};
    w = win('0, '0, $urandom_range(7), 1'b0);
    for (int k = 0; k < n; k++) begin
      if (k == 0) begin
        s = $urandom_range(1) ? '0 : {1'b0, rand_upto(stride)};
      end else begin
        case ($urandom_range(2))
          0: s = {1'b0, w.win_stop};
          1: s = {1'b0, w.win_stop} + {1'b0, rand_upto(stride)} + {{TimeW{1'b0}}, 1'b1};
          default: s = (w.win_stop >= w.win_start) ?
                       {1'b0, w.win_start} +
                       {1'b0, rand_upto({1'b0, w.win_stop - w.win_start})} :
                       {1'b0, w.win_stop};
        endcase
      end
      s = {1'b0, clamp_time(s)};
      e = {1'b0, clamp_time(s + {1'b0, rand_upto(stride)})};
      q = ($urandom_range(9) < 4) ? w.queue : $urandom_range(7);
      if ($urandom_range(99) < 12) begin
        w = win($urandom, $urandom, $urandom_range(7), $urandom_range(7) == 0);
      end else begin
        w = win(s[TimeW-1:0], e[TimeW-1:0], q, 1'b0);
      end
      if (k == n - 1) w.closes_list = 1'b1;
      offer_window(w);
    end
    count = n;
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < quota) begin
      // keep the first list of a phase so a pending hold-off meets live traffic
      if (sent != 0 && $urandom_range(2) == 0) pick_settings();
      random_list(n);
      sent += n;
    end
  endtask

  initial begin : stimulus
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: cycle 1000000, no guard band, eight queues.
    send_idle_pct = 20;
    recv_idle_pct = 40;
    offer_window(win(0, 100, 0, 1'b0));     // first window at zero: no leading span
    offer_window(win(100, 250, 0, 1'b0));   // same queue touching: stretch
    offer_window(win(200, 180, 0, 1'b0));   // same queue overlapping: stop moves back
    offer_window(win(170, 300, 3, 1'b0));   // other queue overlapping
    offer_window(win(500, 600, 7, 1'b0));   // disjoint: held entry plus gap
    offer_window(win(550, 900, 7, 1'b1));   // stretch then close with the tail

    // Queue beyond the count, guard band that fits and one that does not.
    configure(5000, 100, 4);
    offer_window(win(1000, 2000, 5, 1'b1));
    offer_window(win(10, 20, 1, 1'b0));
    offer_window(win(4850, 4950, 2, 1'b1));
    offer_window(win(100, 6000, 0, 1'b1));  // stop past the cycle end

    // Full-range cycle and guard band, zero queues.
    configure('1, 32'h7FFF_FFFF, 0);
    offer_window(win('1, '1, 7, 1'b0));
    offer_window(win(0, 0, 0, 1'b1));

    // Shortest cycle, queue count above the gate count.
    configure(1, 0, 15);
    offer_window(win(0, 0, 6, 1'b0));
    offer_window(win(1, '1, 6, 1'b0));
    offer_window(win(32'h8000_0000, 5, 2, 1'b0));
    offer_window(win(3, 4, 2, 1'b1));

    // Single queue; the last pair yields the most entries one window can.
    configure(1000, 0, 1);
    offer_window(win(0, 999, 0, 1'b1));
    offer_window(win(0, 10, 0, 1'b0));
    offer_window(win(20, 30, 1, 1'b1));

    send_idle_pct = 34;
    recv_idle_pct = 62;
    random_phase(PhaseWindows);
    send_idle_pct = 62;
    recv_idle_pct = 34;
    random_phase(PhaseWindows);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req     = 1'b1;
    random_phase(PhaseWindows);
    drain();

    if (board.pending_entries.size() != 0) begin
      board.errors++;
      $display("%0t: %0d expected entries never arrived, next start %h stop %h gates %h",
               $time, board.pending_entries.size(), board.pending_entries[0].ent_start,
               board.pending_entries[0].ent_stop, board.pending_entries[0].gates);
    end
    $display("Run covered %0d windows in %0d closed lists over %0d register sets, %0d entries.",
             board.windows_seen, board.lists_closed, board.settings_used, board.entries_seen);
    $display("Idle mixes sender/receiver 34/62, 62/34, none, plus a %0d-cycle hold-off.",
             HoldOffCycles);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
